>>> rtl/selective_repeat_receiver_unit_macros.svh
// Assertion macros for the selective repeat receiver.
// No dependencies; included by the top level.
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/srr_pkg.sv
// Shared types and constants of the selective repeat receiver.
// No dependencies.
package srr_pkg;

    // result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_STRAY = 2'd1;
    localparam logic [1:0] KIND_DLV   = 2'd2;

    localparam logic [2:0] WIN_RESET = 3'd4;
    localparam int         WIN_CAP   = 4;
    // delivery counter value of the last delivery allowed per packet
    localparam logic [1:0] CNT_LAST  = 2'd3;

    typedef struct packed {
        logic cap;      // capture input packet
        logic ld_ack;   // load ack result, store payload if in window
        logic rd;       // read payload at window base
        logic ld_dlv;   // load delivery result, advance base
    } t_cmd;

    typedef struct packed {
        logic ok;        // captured packet checksum good
        logic in_win;    // captured packet inside window
        logic ack_last;  // ack is the last result of the packet
        logic dlv_last;  // delivery now due is the last one
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

>>> rtl/srr_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module srr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/srr_dp.sv
// Datapath of the selective repeat receiver: window state, marks, payload RAM,
// output register. Depends on srr_pkg and srr_ram.
module srr_dp #(
    parameter int SEQ_SPACE    = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srr_pkg::t_cmd      i_cmd,
    output srr_pkg::t_sts      o_sts,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_window_size,
    input  logic [2:0]         i_seq_num,
    input  logic               i_checksum_ok,
    input  logic [31:0]        i_payload_word,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_out_kind,
    output logic [2:0]         o_ack_num,
    output logic [31:0]        o_deliver_data,
    output logic               o_last_of_run
);

    localparam int AW  = $clog2(SEQ_SPACE);
    localparam int EW  = ((AW > 3) ? AW : 3) + 1;
    localparam int SW  = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int CAP = (srr_pkg::WIN_CAP < SEQ_SPACE / 2) ? srr_pkg::WIN_CAP
                                                            : SEQ_SPACE / 2;
    localparam logic [2:0]    CAP_W  = 3'(CAP);
    localparam logic [EW-1:0] SPACE  = EW'(SEQ_SPACE);
    localparam logic [AW-1:0] TOP    = AW'(SEQ_SPACE - 1);
    localparam logic [AW-1:0] BASE0  = AW'(1 % SEQ_SPACE);

    logic [2:0]    r_win;
    logic [AW-1:0] r_base;
    logic          r_marks [SEQ_SPACE];
    logic [1:0]    r_cnt;
    logic [2:0]    r_seq;
    logic          r_ok;
    logic [SW-1:0] r_data;
    logic          r_o_valid;
    logic [1:0]    r_kind;
    logic [2:0]    r_ack;
    logic [31:0]   r_dout;
    logic          r_last;

    logic [2:0]    w_width;
    logic [EW-1:0] w_seq_e;
    logic [EW-1:0] w_base_e;
    logic [EW-1:0] w_sum;
    logic [EW-1:0] w_diff;
    logic [AW-1:0] w_seq_a;
    logic [AW-1:0] w_next;
    logic          w_in_win;
    logic          w_ack_last;
    logic          w_dlv_last;
    logic          w_out_free;
    logic [SW-1:0] w_rdata;

    // window width clamped to 1..CAP
    always_comb begin
        if (r_win == 3'd0) begin
            w_width = 3'd1;
        end else if (r_win > CAP_W) begin
            w_width = CAP_W;
        end else begin
            w_width = r_win;
        end
    end

    // (seq - base) mod SEQ_SPACE, both operands below SEQ_SPACE when it matters
    assign w_seq_e  = EW'(r_seq);
    assign w_base_e = EW'(r_base);
    assign w_sum    = w_seq_e + SPACE - w_base_e;
    assign w_diff   = (w_sum >= SPACE) ? (w_sum - SPACE) : w_sum;
    assign w_in_win = (w_seq_e < SPACE) && (w_diff < EW'(w_width));
    assign w_seq_a  = w_seq_e[AW-1:0];
    assign w_next   = (r_base == TOP) ? '0 : (r_base + AW'(1));

    assign w_ack_last = !(r_marks[r_base] || (w_seq_a == r_base));
    assign w_dlv_last = (r_cnt == srr_pkg::CNT_LAST) || !r_marks[w_next];
    assign w_out_free = !r_o_valid || i_ready;

    assign o_sts.ok       = r_ok;
    assign o_sts.in_win   = w_in_win;
    assign o_sts.ack_last = w_ack_last;
    assign o_sts.dlv_last = w_dlv_last;
    assign o_sts.out_free = w_out_free;

    srr_ram #(
        .WIDTH (SW),
        .DEPTH (SEQ_SPACE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_ack && w_in_win),
        .i_waddr (w_seq_a),
        .i_wdata (r_data),
        .i_re    (i_cmd.rd),
        .i_raddr (r_base),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_seq  <= i_seq_num;
            r_ok   <= i_checksum_ok;
            r_data <= i_payload_word[SW-1:0];
        end
        if (i_cmd.ld_ack) begin
            r_kind <= w_in_win ? srr_pkg::KIND_ACK : srr_pkg::KIND_STRAY;
            r_ack  <= r_seq;
            r_dout <= '0;
            r_last <= !w_in_win || w_ack_last;
        end else if (i_cmd.ld_dlv) begin
            r_kind <= srr_pkg::KIND_DLV;
            r_ack  <= w_base_e[2:0];
            r_dout <= 32'(w_rdata);
            r_last <= w_dlv_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= srr_pkg::WIN_RESET;
            r_base    <= BASE0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < SEQ_SPACE; i++) begin
                r_marks[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_win <= i_cfg_window_size;
            end
            if (i_cmd.ld_ack || i_cmd.ld_dlv) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.ld_ack) begin
                r_cnt <= '0;
                if (w_in_win) begin
                    r_marks[w_seq_a] <= 1'b1;
                end
            end
            if (i_cmd.ld_dlv) begin
                r_marks[r_base] <= 1'b0;
                r_base          <= w_next;
                r_cnt           <= r_cnt + 2'd1;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_kind     = r_kind;
    assign o_ack_num      = r_ack;
    assign o_deliver_data = r_dout;
    assign o_last_of_run  = r_last;

endmodule

>>> rtl/srr_ctrl.sv
// Sequencer of the selective repeat receiver: capture, ack, read/deliver loop.
// Depends on srr_pkg.
module srr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  srr_pkg::t_sts i_sts,
    output srr_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_RD   = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_sts.ok) begin
                    n_state = S_IDLE;   // corrupt packet: dropped silently
                end else if (i_sts.out_free) begin
                    o_cmd.ld_ack = 1'b1;
                    if (!i_sts.in_win || i_sts.ack_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_dlv = 1'b1;
                    n_state      = i_sts.dlv_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/selective_repeat_receiver_unit.sv
// Selective repeat ARQ receiver, top level. Depends on srr_pkg, srr_ctrl, srr_dp.
// Per packet: capture, then, for a good checksum, the ack load once the output
// register is free, then per delivered payload a RAM read and an output load. No
// new packet is taken while one is in work; at most 4 deliveries per packet.
// Reset (sync, active low): window base 1, marks cleared, window width 4;
// payload RAM contents are not cleared.
`include "selective_repeat_receiver_unit_macros.svh"

module selective_repeat_receiver_unit #(
    parameter int SEQ_SPACE    = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_window_size,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_seq_num,
    input  logic        i_checksum_ok,
    input  logic [31:0] i_payload_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_out_kind,
    output logic [2:0]  o_ack_num,
    output logic [31:0] o_deliver_data,
    output logic        o_last_of_run
);

    srr_pkg::t_cmd w_cmd;
    srr_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    srr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    srr_dp #(
        .SEQ_SPACE    (SEQ_SPACE),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_window_size (i_cfg_window_size),
        .i_seq_num         (i_seq_num),
        .i_checksum_ok     (i_checksum_ok),
        .i_payload_word    (i_payload_word),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_kind        (o_out_kind),
        .o_ack_num         (o_ack_num),
        .o_deliver_data    (o_deliver_data),
        .o_last_of_run     (o_last_of_run)
    );

    // a result may only be loaded when the pending one leaves this cycle
    `SRR_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, (w_cmd.ld_ack || w_cmd.ld_dlv), (!o_valid || i_ready), "result overwritten")
    // one packet in work at a time
    `SRR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, (i_valid && o_ready), !o_ready, "second packet taken while busy")
    // a stray ack ends its run
    `SRR_ASSERT_NOW(a_stray_last, i_clk, i_rst_n, (o_valid && (o_out_kind == srr_pkg::KIND_STRAY)), o_last_of_run, "stray ack not last")
    // no ack load follows straight after a payload read
    `SRR_ASSERT_NEXT(a_rd_then_dlv, i_clk, i_rst_n, w_cmd.rd, !w_cmd.ld_ack, "ack load after payload read")

endmodule

>>> bench/tb_selective_repeat_receiver_unit.sv
// Self-checking bench for selective_repeat_receiver_unit: directed table, then random traffic.
// Predicts acks, stray acks and in-order deliveries per packet and compares every output transfer.
// Depends on srr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module tb_selective_repeat_receiver_unit;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_GOOD   = 330;
    localparam int NOT_TYPED     = -1;

    typedef enum logic {ROW_PKT, ROW_CFG} t_row_kind;

    // seq doubles as the window width on config rows
    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  seq;
        logic        ok;
        logic [31:0] data;
        int          exp_n;
        logic [1:0]  exp_kind;
    } t_row;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  ack;
        logic [31:0] data;
        logic        last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_window_size;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_seq_num;
    logic        i_checksum_ok;
    logic [31:0] i_payload_word;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_out_kind;
    logic [2:0]  o_ack_num;
    logic [31:0] o_deliver_data;
    logic        o_last_of_run;

    // receiver state as the bench sees it
    logic [2:0]  win_base;
    logic [2:0]  win_cfg;
    logic        rx_marks [8];
    logic [31:0] rx_store [8];

    t_result     burst [srr_pkg::WIN_CAP + 1];
    int          burst_len;
    t_result     due_results [$];

    logic        src_steady;
    logic        sink_steady;
    int          errors;
    int          pkt_count;
    int          good_count;
    int          stray_count;
    int          full_bursts;
    int          results_seen;
    int          cfg_writes;

    t_row        dir_rows [0:27];

    selective_repeat_receiver_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_window_size (i_cfg_window_size),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_seq_num         (i_seq_num),
        .i_checksum_ok     (i_checksum_ok),
        .i_payload_word    (i_payload_word),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_kind        (o_out_kind),
        .o_ack_num         (o_ack_num),
        .o_deliver_data    (o_deliver_data),
        .o_last_of_run     (o_last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // 0 behaves as 1, anything above the cap as the cap
    function automatic int window_span();
        if (win_cfg == 3'd0)
            return 1;
        if (win_cfg > srr_pkg::WIN_CAP)
            return srr_pkg::WIN_CAP;
        return int'(win_cfg);
    endfunction

    function automatic void arq_receive(logic [2:0] seq, logic ok, logic [31:0] data);
        int k;
        burst_len = 0;
        if (!ok)
            return;
        if (int'(3'(seq - win_base)) >= window_span()) begin
            burst[0]  = '{srr_pkg::KIND_STRAY, seq, 32'd0, 1'b1};
            burst_len = 1;
            return;
        end
        burst[0]       = '{srr_pkg::KIND_ACK, seq, 32'd0, 1'b0};
        burst_len      = 1;
        rx_store[seq]  = data;
        rx_marks[seq]  = 1'b1;
        // delivery follows the marks, capped per packet, even if the window shrank
        for (k = 0; k < srr_pkg::WIN_CAP; k++) begin
            if (!rx_marks[win_base])
                break;
            burst[burst_len]   = '{srr_pkg::KIND_DLV, win_base, rx_store[win_base], 1'b0};
            burst_len++;
            rx_marks[win_base] = 1'b0;
            win_base           = win_base + 3'd1;
        end
        burst[burst_len - 1].last = 1'b1;
    endfunction

    // entered and left at a falling edge
    task automatic send_packet(logic [2:0] seq, logic ok, logic [31:0] data,
                               int exp_n, logic [1:0] exp_kind);
        int gap;
        int k;
        gap = src_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_seq_num      <= seq;
        i_checksum_ok  <= ok;
        i_payload_word <= data;
        do @(posedge i_clk); while (!o_ready);
        arq_receive(seq, ok, data);
        for (k = 0; k < burst_len; k++)
            due_results.push_back(burst[k]);
        pkt_count++;
        if (burst_len > 0 && burst[0].kind == srr_pkg::KIND_STRAY)
            stray_count++;
        if (burst_len == srr_pkg::WIN_CAP + 1)
            full_bursts++;
        if (exp_n != NOT_TYPED) begin
            if (burst_len != exp_n) begin
                $error("packet seq %0d: result count expected %0d, predicted %0d",
                       seq, exp_n, burst_len);
                errors++;
            end else if (exp_n > 0 && burst[0].kind != exp_kind) begin
                $error("packet seq %0d: out_kind expected %0d, predicted %0d",
                       seq, exp_kind, burst[0].kind);
                errors++;
            end
        end
        @(negedge i_clk);
    endtask

    // drain everything outstanding; a corrupt packet may still be in flight
    task automatic settle();
        i_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_window(logic [2:0] width);
        i_cfg_valid       <= 1'b1;
        i_cfg_window_size <= width;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_cfg = width;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_packet();
        int          r;
        logic [2:0]  seq;
        logic        ok;
        logic [31:0] data;
        r    = $urandom_range(0, 99);
        data = $urandom;
        ok   = 1'b1;
        if (r < 10) begin
            seq = 3'($urandom_range(0, 7));
            ok  = 1'b0;
        end else if (r < 25) begin
            seq = 3'($urandom_range(0, 7));
        end else begin
            seq = win_base + 3'($urandom_range(0, window_span() - 1));
        end
        if (ok)
            good_count++;
        send_packet(seq, ok, data, NOT_TYPED, srr_pkg::KIND_ACK);
    endtask

    // output side: random stall before each transfer, then compare with the oldest expectation
    initial begin : result_checker
        int      gap;
        t_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            gap = sink_steady ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            results_seen++;
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d ack %0d data %h last %0b",
                       o_out_kind, o_ack_num, o_deliver_data, o_last_of_run);
                errors++;
            end else begin
                want = due_results.pop_front();
                if (o_out_kind !== want.kind) begin
                    $error("out_kind expected %0d got %0d", want.kind, o_out_kind);
                    errors++;
                end
                if (o_ack_num !== want.ack) begin
                    $error("ack_num expected %0d got %0d", want.ack, o_ack_num);
                    errors++;
                end
                if (o_deliver_data !== want.data) begin
                    $error("deliver_data expected %h got %h", want.data, o_deliver_data);
                    errors++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run expected %0b got %0b", want.last, o_last_of_run);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still due",
                 cycle_count, due_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int         i;
        int         r;
        logic [2:0] width;

        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_window_size = 3'd0;
        i_valid           = 1'b0;
        i_seq_num         = 3'd0;
        i_checksum_ok     = 1'b0;
        i_payload_word    = 32'd0;
        i_ready           = 1'b0;
        src_steady        = 1'b0;
        sink_steady       = 1'b0;
        errors            = 0;
        pkt_count         = 0;
        good_count        = 0;
        stray_count       = 0;
        full_bursts       = 0;
        results_seen      = 0;
        cfg_writes        = 0;
        win_base          = 3'd1;
        win_cfg           = srr_pkg::WIN_RESET;
        for (i = 0; i < 8; i++) begin
            rx_marks[i] = 1'b0;
            rx_store[i] = 32'd0;
        end

        // reset window is 1..4
        dir_rows = '{
            '{ROW_PKT, 3'd0, 1'b1, 32'h1111_0000, 1, srr_pkg::KIND_STRAY},
            '{ROW_PKT, 3'd5, 1'b1, 32'h5555_0005, 1, srr_pkg::KIND_STRAY},
            '{ROW_PKT, 3'd3, 1'b0, 32'hDEAD_BEEF, 0, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd2, 1'b1, 32'hFFFF_FFFF, 1, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd4, 1'b1, 32'h0000_0000, 1, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd3, 1'b1, 32'hA5A5_A5A5, NOT_TYPED, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd2, 1'b1, 32'h1234_5678, NOT_TYPED, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd1, 1'b1, 32'h0000_0001, 5, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd4, 1'b1, 32'h4444_4444, 1, srr_pkg::KIND_STRAY},
            '{ROW_PKT, 3'd0, 1'b1, 32'h0F0F_0F0F, NOT_TYPED, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd7, 1'b1, 32'h7777_7777, NOT_TYPED, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd6, 1'b1, 32'h6666_6666, NOT_TYPED, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd5, 1'b1, 32'h5A5A_5A5A, 5, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd1, 1'b0, 32'hFFFF_FFFF, 0, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd1, 1'b1, 32'h8000_0000, 2, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd3, 1'b1, 32'h3333_3333, NOT_TYPED, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd5, 1'b1, 32'hC0DE_0005, NOT_TYPED, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd4, 1'b1, 32'hC0DE_0004, NOT_TYPED, srr_pkg::KIND_ACK},
            // shrink the window with three marks pending
            '{ROW_CFG, 3'd1, 1'b0, 32'd0, NOT_TYPED, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd3, 1'b1, 32'hBAD0_0003, 1, srr_pkg::KIND_STRAY},
            '{ROW_PKT, 3'd2, 1'b1, 32'h0000_0000, 5, srr_pkg::KIND_ACK},
            '{ROW_CFG, 3'd0, 1'b0, 32'd0, NOT_TYPED, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd7, 1'b1, 32'h7070_7070, 1, srr_pkg::KIND_STRAY},
            '{ROW_PKT, 3'd6, 1'b1, 32'h6060_6060, 2, srr_pkg::KIND_ACK},
            '{ROW_CFG, 3'd7, 1'b0, 32'd0, NOT_TYPED, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd2, 1'b1, 32'h2222_2222, 1, srr_pkg::KIND_ACK},
            '{ROW_PKT, 3'd3, 1'b1, 32'h3030_3030, 1, srr_pkg::KIND_STRAY},
            '{ROW_CFG, 3'd4, 1'b0, 32'd0, NOT_TYPED, srr_pkg::KIND_ACK}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (i = 0; i < $size(dir_rows); i++) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                write_window(dir_rows[i].seq);
            end else begin
                send_packet(dir_rows[i].seq, dir_rows[i].ok, dir_rows[i].data,
                            dir_rows[i].exp_n, dir_rows[i].exp_kind);
            end
        end

        // random phases, each with its own window width and idling pattern
        while (good_count < RANDOM_GOOD) begin
            settle();
            r = $urandom_range(0, 9);
            if (r < 2)
                width = 3'd1;
            else if (r < 4)
                width = 3'd4;
            else
                width = 3'($urandom_range(0, 7));
            write_window(width);
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 50)) random_packet();
        end
        settle();

        $display("Sent %0d packets (%0d stray acks, %0d with a full run of deliveries)",
                 pkt_count, stray_count, full_bursts);
        $display("Checked %0d result transfers over %0d window writes", results_seen, cfg_writes);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
